// ===== hw/rtl/etpq_pkg.sv =====
// Shared types and constants for the event timer priority queue.
// Holds the transfer structs, operation and status codes. No dependencies.
package etpq_pkg;

  localparam int EVENT_SLOTS = 16;
  localparam int SLOT_W      = 4;
  localparam int CNT_W       = 5;
  localparam int SEQ_W       = 32;
  localparam int TICK_W      = 64;

  localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_ADVANCE  = 2'd2,
    OP_RESERVED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_STALE   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [TICK_W-1:0]  tick;
    logic [7:0]         event_kind;
    logic [15:0]        event_context;
    logic [3:0]         cancel_slot;
    logic [31:0]        cancel_sequence;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    status_e            status;
    logic [7:0]         fired_kind;
    logic [15:0]        fired_context;
    logic [TICK_W-1:0]  fired_tick;
    logic [3:0]         token_slot;
    logic [31:0]        token_sequence;
    logic               next_due_valid;
    logic [TICK_W-1:0]  next_due_tick;
    logic [4:0]         pending_count;
    logic               last;
  } out_t;

endpackage

// ===== hw/rtl/etpq_front.sv =====
// Front end of the event timer queue: a two-entry command queue.
// Depends on etpq_pkg for the input transfer struct.
module etpq_front import etpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic cmd_valid_o,
  input  logic cmd_pop_i,
  output in_t  cmd_o
);

  in_t        mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        mem_q[wr_q] <= in_i;
        wr_q        <= !wr_q;
      end
      if (cmd_pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

endmodule

// ===== hw/rtl/etpq_heap.sv =====
// Back end of the event timer queue: slot table, min-heap sequencer and result register.
// Depends on etpq_pkg for transfer structs and codes.
module etpq_heap import etpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  input  in_t  cmd_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_FIX, S_UP, S_DOWN, S_ADV, S_EMIT
  } state_e;

  state_e             state_q;
  logic [TICK_W-1:0]  due_q   [EVENT_SLOTS];
  logic [SEQ_W-1:0]   seq_q   [EVENT_SLOTS];
  logic [7:0]         kind_q  [EVENT_SLOTS];
  logic [15:0]        ctx_q   [EVENT_SLOTS];
  logic [SLOT_W-1:0]  pos_q   [EVENT_SLOTS];
  logic [SLOT_W-1:0]  order_q [EVENT_SLOTS];
  logic [EVENT_SLOTS-1:0] active_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [TICK_W-1:0]  cur_q;
  logic [SEQ_W-1:0]   seqc_q;
  in_t                item_q;
  out_t               res_q;
  logic               loop_q;
  logic [SLOT_W-1:0]  idx_q;
  out_t               out_q;
  logic               out_valid_q;
  out_t               emit_res;

  function automatic logic before_f(input logic [TICK_W-1:0] ta, input logic [SEQ_W-1:0] qa,
                                    input logic [TICK_W-1:0] tb, input logic [SEQ_W-1:0] qb);
    return (ta < tb) || ((ta == tb) && (qa < qb));
  endfunction

  function automatic out_t res_f(input logic rk, input status_e st, input logic [7:0] fk,
                                 input logic [15:0] fc, input logic [TICK_W-1:0] ft,
                                 input logic [SLOT_W-1:0] ts, input logic [SEQ_W-1:0] tq,
                                 input logic lst);
    out_t r;
    r                = '0;
    r.result_kind    = rk;
    r.status         = st;
    r.fired_kind     = fk;
    r.fired_context  = fc;
    r.fired_tick     = ft;
    r.token_slot     = ts;
    r.token_sequence = tq;
    r.last           = lst;
    return r;
  endfunction

  logic [SLOT_W-1:0] free_idx;
  logic              free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int k = EVENT_SLOTS - 1; k >= 0; k--) begin
      if (!active_q[k]) begin
        free_idx = SLOT_W'(k);
        free_any = 1'b1;
      end
    end
  end

  logic [SLOT_W-1:0] par;
  logic [SLOT_W-1:0] a_sl, p_sl, l_sl, r_sl, m_sl, m_idx;
  logic [CNT_W:0]    l_ix, r_ix;
  logic              up_less, l_less, r_less;
  logic [SLOT_W-1:0] cs;
  logic [CNT_W-1:0]  last_pos;
  logic [SLOT_W-1:0] top_sl;

  always_comb begin
    par     = (idx_q - SLOT_W'(1)) >> 1;
    a_sl    = order_q[idx_q];
    p_sl    = order_q[par];
    up_less = before_f(due_q[a_sl], seq_q[a_sl], due_q[p_sl], seq_q[p_sl]);
    l_ix    = {idx_q, 1'b0} + (CNT_W+1)'(1);
    r_ix    = l_ix + (CNT_W+1)'(1);
    l_sl    = order_q[l_ix[SLOT_W-1:0]];
    r_sl    = order_q[r_ix[SLOT_W-1:0]];
    l_less  = (l_ix < {1'b0, cnt_q}) &&
              before_f(due_q[l_sl], seq_q[l_sl], due_q[a_sl], seq_q[a_sl]);
    m_sl    = l_less ? l_sl : a_sl;
    m_idx   = l_less ? l_ix[SLOT_W-1:0] : idx_q;
    r_less  = (r_ix < {1'b0, cnt_q}) &&
              before_f(due_q[r_sl], seq_q[r_sl], due_q[m_sl], seq_q[m_sl]);
    if (r_less) begin
      m_sl  = r_sl;
      m_idx = r_ix[SLOT_W-1:0];
    end
    cs       = item_q.cancel_slot;
    last_pos = cnt_q - CNT_W'(1);
    top_sl   = order_q[0];
    emit_res                = res_q;
    emit_res.next_due_valid = (cnt_q != '0);
    emit_res.next_due_tick  = (cnt_q != '0) ? due_q[top_sl] : '0;
    emit_res.pending_count  = cnt_q;
  end

  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      cnt_q       <= '0;
      cur_q       <= '0;
      seqc_q      <= '0;
      loop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            item_q  <= cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          loop_q <= 1'b0;
          case (item_q.op)
            OP_SCHEDULE: begin
              if (item_q.tick < cur_q || seqc_q == SEQ_MAX) begin
                res_q   <= res_f(1'b0, ST_INVALID, '0, '0, '0, '0, '0, 1'b1);
                state_q <= S_EMIT;
              end else if (!free_any) begin
                res_q   <= res_f(1'b0, ST_FULL, '0, '0, '0, '0, '0, 1'b1);
                state_q <= S_EMIT;
              end else begin
                due_q[free_idx]  <= item_q.tick;
                seq_q[free_idx]  <= seqc_q;
                kind_q[free_idx] <= item_q.event_kind;
                ctx_q[free_idx]  <= item_q.event_context;
                pos_q[free_idx]  <= cnt_q[SLOT_W-1:0];
                active_q[free_idx] <= 1'b1;
                order_q[cnt_q[SLOT_W-1:0]] <= free_idx;
                cnt_q  <= cnt_q + CNT_W'(1);
                seqc_q <= seqc_q + SEQ_W'(1);
                res_q  <= res_f(1'b0, ST_OK, '0, '0, '0, free_idx, seqc_q, 1'b1);
                idx_q   <= cnt_q[SLOT_W-1:0];
                state_q <= S_UP;
              end
            end
            OP_CANCEL: begin
              if ({1'b0, item_q.cancel_slot} >= CNT_W'(EVENT_SLOTS)) begin
                res_q   <= res_f(1'b0, ST_INVALID, '0, '0, '0, '0, '0, 1'b1);
                state_q <= S_EMIT;
              end else if (!active_q[cs] || seq_q[cs] != item_q.cancel_sequence) begin
                res_q   <= res_f(1'b0, ST_STALE, '0, '0, '0, '0, '0, 1'b1);
                state_q <= S_EMIT;
              end else begin
                res_q        <= res_f(1'b0, ST_OK, '0, '0, '0, '0, '0, 1'b1);
                active_q[cs] <= 1'b0;
                cnt_q        <= last_pos;
                if ({1'b0, pos_q[cs]} != last_pos) begin
                  order_q[pos_q[cs]] <= order_q[last_pos[SLOT_W-1:0]];
                  pos_q[order_q[last_pos[SLOT_W-1:0]]] <= pos_q[cs];
                  idx_q   <= pos_q[cs];
                  state_q <= S_FIX;
                end else begin
                  state_q <= S_EMIT;
                end
              end
            end
            OP_ADVANCE: begin
              if (item_q.tick < cur_q) begin
                res_q   <= res_f(1'b0, ST_INVALID, '0, '0, '0, '0, '0, 1'b1);
                state_q <= S_EMIT;
              end else begin
                state_q <= S_ADV;
              end
            end
            default: begin
              res_q   <= res_f(1'b0, ST_INVALID, '0, '0, '0, '0, '0, 1'b1);
              state_q <= S_EMIT;
            end
          endcase
        end
        S_FIX: begin
          state_q <= (idx_q != '0 && up_less) ? S_UP : S_DOWN;
        end
        S_UP: begin
          if (idx_q != '0 && up_less) begin
            order_q[idx_q] <= p_sl;
            order_q[par]   <= a_sl;
            pos_q[p_sl]    <= idx_q;
            pos_q[a_sl]    <= par;
            idx_q          <= par;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_DOWN: begin
          if (m_idx != idx_q) begin
            order_q[idx_q] <= m_sl;
            order_q[m_idx] <= a_sl;
            pos_q[m_sl]    <= idx_q;
            pos_q[a_sl]    <= m_idx;
            idx_q          <= m_idx;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_ADV: begin
          if (cnt_q != '0 && due_q[top_sl] <= item_q.tick) begin
            active_q[top_sl] <= 1'b0;
            cur_q            <= due_q[top_sl];
            res_q            <= res_f(1'b1, ST_OK, kind_q[top_sl], ctx_q[top_sl],
                                      due_q[top_sl], '0, '0, 1'b0);
            loop_q           <= 1'b1;
            cnt_q            <= last_pos;
            if (last_pos != '0) begin
              order_q[0] <= order_q[last_pos[SLOT_W-1:0]];
              pos_q[order_q[last_pos[SLOT_W-1:0]]] <= '0;
              idx_q   <= '0;
              state_q <= S_DOWN;
            end else begin
              state_q <= S_EMIT;
            end
          end else begin
            cur_q   <= item_q.tick;
            res_q   <= res_f(1'b0, ST_OK, '0, '0, '0, '0, '0, 1'b1);
            loop_q  <= 1'b0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= emit_res;
            out_valid_q <= 1'b1;
            state_q     <= loop_q ? S_ADV : S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/event_timer_priority_queue.sv =====
// Top level of the event timer priority queue: command queue plus heap engine.
// Depends on etpq_pkg, etpq_front and etpq_heap.
//
// Commands enter a two-entry queue and are carried out one at a time by a heap
// sequencer that does one compare-and-swap per cycle over sixteen slots. An
// advance fires each due event in turn, and output stalls hold the sequencer
// in its emit state. Each result waits in an output register while the next
// command is taken into the queue.
module event_timer_priority_queue import etpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic cmd_valid, cmd_pop;
  in_t  cmd;

  etpq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  etpq_heap u_heap (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .out_o
  );

`ifndef NO_ASSERTIONS
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.pending_count <= CNT_W'(EVENT_SLOTS)) else $error("count overflow");
  a_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.next_due_valid == (out_o.pending_count != '0)) else $error("due flag");
  a_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.result_kind) |-> (out_o.status == ST_OK && !out_o.last))
    else $error("fired result");
`endif

endmodule

// ===== sim/tb_event_timer_priority_queue.sv =====
// Self-checking testbench for the event timer priority queue.
// Depends on etpq_pkg and event_timer_priority_queue; holds its own heap predictor.
module tb_event_timer_priority_queue;
  import etpq_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_o;

  event_timer_priority_queue u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_o(out_o)
  );

  // Predictor state.
  logic [TICK_W-1:0] due_q [EVENT_SLOTS];
  logic [SEQ_W-1:0]  seq_q [EVENT_SLOTS];
  logic [7:0]        kind_q [EVENT_SLOTS];
  logic [15:0]       ctx_q [EVENT_SLOTS];
  int                hpos_q [EVENT_SLOTS];
  bit                active_q [EVENT_SLOTS];
  int                order_q [EVENT_SLOTS];
  int                heap_cnt;
  logic [TICK_W-1:0] now_tick;
  logic [SEQ_W-1:0]  seq_ctr;

  in_t  pending_cmds [$];
  out_t expected_results [$];
  int   errors;
  int   fired_seen;
  int   cmds_sent;
  bit   drain_done;
  bit   no_idle;
  int   hold_cycles;
  int   quiet_cycles;

  function automatic bit earlier(int a, int b);
    return due_q[a] < due_q[b] || (due_q[a] == due_q[b] && seq_q[a] < seq_q[b]);
  endfunction

  function automatic void swap_pos(int i, int j);
    int t;
    t = order_q[i];
    order_q[i] = order_q[j];
    order_q[j] = t;
    hpos_q[order_q[i]] = i;
    hpos_q[order_q[j]] = j;
  endfunction

  function automatic void bubble_up(int i);
    int p;
    while (i != 0) begin
      p = (i - 1) / 2;
      if (!earlier(order_q[i], order_q[p])) break;
      swap_pos(i, p);
      i = p;
    end
  endfunction

  function automatic void bubble_down(int i);
    int l, r, m;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < heap_cnt && earlier(order_q[l], order_q[m])) m = l;
      if (r < heap_cnt && earlier(order_q[r], order_q[m])) m = r;
      if (m == i) return;
      swap_pos(i, m);
      i = m;
    end
  endfunction

  function automatic void remove_at(int i);
    int lp;
    if (i >= heap_cnt) return;
    heap_cnt--;
    lp = heap_cnt;
    if (i == lp) return;
    order_q[i] = order_q[lp];
    hpos_q[order_q[i]] = i;
    if (i != 0 && earlier(order_q[i], order_q[(i - 1) / 2])) bubble_up(i);
    else bubble_down(i);
  endfunction

  function automatic void push_result(bit rk, status_e st, logic [7:0] fk,
                                      logic [15:0] fc, logic [TICK_W-1:0] ft,
                                      logic [3:0] ts, logic [SEQ_W-1:0] tq, bit lst);
    out_t r;
    r.result_kind    = rk;
    r.status         = st;
    r.fired_kind     = fk;
    r.fired_context  = fc;
    r.fired_tick     = ft;
    r.token_slot     = ts;
    r.token_sequence = tq;
    r.next_due_valid = heap_cnt != 0;
    r.next_due_tick  = heap_cnt != 0 ? due_q[order_q[0]] : '0;
    r.pending_count  = heap_cnt[4:0];
    r.last           = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_timer(in_t c);
    int s;
    int n;
    case (c.op)
      OP_SCHEDULE: begin
        if (c.tick < now_tick || seq_ctr == SEQ_MAX) begin
          push_result(0, ST_INVALID, 0, 0, 0, 0, 0, 1);
          return;
        end
        for (s = 0; s < EVENT_SLOTS; s++) begin
          if (!active_q[s]) begin
            due_q[s] = c.tick;
            seq_q[s] = seq_ctr;
            seq_ctr = seq_ctr + 1;
            kind_q[s] = c.event_kind;
            ctx_q[s] = c.event_context;
            active_q[s] = 1;
            hpos_q[s] = heap_cnt;
            order_q[heap_cnt] = s;
            heap_cnt++;
            bubble_up(hpos_q[s]);
            push_result(0, ST_OK, 0, 0, 0, s[3:0], seq_q[s], 1);
            return;
          end
        end
        push_result(0, ST_FULL, 0, 0, 0, 0, 0, 1);
      end
      OP_CANCEL: begin
        s = c.cancel_slot;
        if (!active_q[s] || seq_q[s] != c.cancel_sequence) begin
          push_result(0, ST_STALE, 0, 0, 0, 0, 0, 1);
          return;
        end
        remove_at(hpos_q[s]);
        active_q[s] = 0;
        push_result(0, ST_OK, 0, 0, 0, 0, 0, 1);
      end
      OP_ADVANCE: begin
        if (c.tick < now_tick) begin
          push_result(0, ST_INVALID, 0, 0, 0, 0, 0, 1);
          return;
        end
        n = 0;
        while (heap_cnt != 0 && n < EVENT_SLOTS) begin
          s = order_q[0];
          if (due_q[s] > c.tick) break;
          remove_at(0);
          active_q[s] = 0;
          now_tick = due_q[s];
          push_result(1, ST_OK, kind_q[s], ctx_q[s], due_q[s], 0, 0, 0);
          n++;
        end
        now_tick = c.tick;
        push_result(0, ST_OK, 0, 0, 0, 0, 0, 1);
      end
      default: push_result(0, ST_INVALID, 0, 0, 0, 0, 0, 1);
    endcase
  endfunction

  function automatic in_t make_cmd(op_e op, logic [TICK_W-1:0] tk, logic [3:0] cs,
                                   logic [SEQ_W-1:0] cq);
    in_t c;
    c.op              = op;
    c.tick            = tk;
    c.event_kind      = 8'($urandom_range(0, 255));
    c.event_context   = 16'($urandom_range(0, 65535));
    c.cancel_slot     = cs;
    c.cancel_sequence = cq;
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [TICK_W-1:0] got,
                                 logic [TICK_W-1:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Clock.
  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Driver: sends the pending commands, predicting each on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      in_i       <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_timer(in_i);
        cmds_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_cmds.size() != 0 && (no_idle || $urandom_range(0, 99) >= 36)) begin
          in_i       <= pending_cmds.pop_front();
          in_valid_i <= 1;
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // Monitor: checks each transfer against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      out_stall_i <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", '0, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_o.result_kind) fired_seen++;
          if (out_o.result_kind !== want.result_kind)
            report_mismatch("result_kind", TICK_W'(out_o.result_kind),
                            TICK_W'(want.result_kind));
          if (out_o.status !== want.status)
            report_mismatch("status", TICK_W'(out_o.status), TICK_W'(want.status));
          if (out_o.fired_kind !== want.fired_kind)
            report_mismatch("fired_kind", TICK_W'(out_o.fired_kind),
                            TICK_W'(want.fired_kind));
          if (out_o.fired_context !== want.fired_context)
            report_mismatch("fired_context", TICK_W'(out_o.fired_context),
                            TICK_W'(want.fired_context));
          if (out_o.fired_tick !== want.fired_tick)
            report_mismatch("fired_tick", out_o.fired_tick, want.fired_tick);
          if (out_o.token_slot !== want.token_slot)
            report_mismatch("token_slot", TICK_W'(out_o.token_slot),
                            TICK_W'(want.token_slot));
          if (out_o.token_sequence !== want.token_sequence)
            report_mismatch("token_sequence", TICK_W'(out_o.token_sequence),
                            TICK_W'(want.token_sequence));
          if (out_o.next_due_valid !== want.next_due_valid)
            report_mismatch("next_due_valid", TICK_W'(out_o.next_due_valid),
                            TICK_W'(want.next_due_valid));
          if (out_o.next_due_tick !== want.next_due_tick)
            report_mismatch("next_due_tick", out_o.next_due_tick, want.next_due_tick);
          if (out_o.pending_count !== want.pending_count)
            report_mismatch("pending_count", TICK_W'(out_o.pending_count),
                            TICK_W'(want.pending_count));
          if (out_o.last !== want.last)
            report_mismatch("last", TICK_W'(out_o.last), TICK_W'(want.last));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1;
      end else begin
        out_stall_i <= !no_idle && !drain_done && $urandom_range(0, 99) < 36;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("event_timer_priority_queue verification failed");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  initial begin
    logic [TICK_W-1:0] t;
    int k, ph;
    errors = 0; fired_seen = 0; cmds_sent = 0; drain_done = 0; no_idle = 0;
    hold_cycles = 0; quiet_cycles = 0; heap_cnt = 0; now_tick = '0; seq_ctr = '0;
    for (k = 0; k < EVENT_SLOTS; k++) active_q[k] = 0;
    rst_ni = 0;
    in_valid_i = 0;
    in_i = '0;
    out_stall_i = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;

    // Directed part: full table, ties, stale tokens, reserved op, past ticks.
    for (k = 0; k < 17; k++)
      pending_cmds.push_back(make_cmd(OP_SCHEDULE, 64'd100 - (k % 3), 0, 0));
    pending_cmds.push_back(make_cmd(OP_CANCEL, 0, 4'd3, 32'd3));
    pending_cmds.push_back(make_cmd(OP_CANCEL, 0, 4'd3, 32'd3));
    pending_cmds.push_back(make_cmd(OP_CANCEL, 0, 4'd15, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(OP_RESERVED, '1, 4'hF, '1));
    pending_cmds.push_back(make_cmd(OP_ADVANCE, 64'd99, 0, 0));
    pending_cmds.push_back(make_cmd(OP_ADVANCE, 64'd50, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SCHEDULE, 64'd10, 0, 0));
    pending_cmds.push_back(make_cmd(OP_ADVANCE, 64'd1000, 0, 0));
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk_i);

    // Back-pressure: receiver holds off while schedules keep coming.
    hold_cycles = 300;
    for (k = 0; k < 10; k++)
      pending_cmds.push_back(make_cmd(OP_SCHEDULE, 64'd2000 + k, 0, 0));
    pending_cmds.push_back(make_cmd(OP_ADVANCE, 64'd3000, 0, 0));

    // Random phases: mostly near-future ticks, and cancels with recent sequence numbers on random slots.
    for (ph = 0; ph < 6; ph++) begin
      while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
      no_idle = (ph == 2);
      for (k = 0; k < 55; k++) begin
        t = now_tick + $urandom_range(0, 40);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: pending_cmds.push_back(make_cmd(OP_SCHEDULE, t, 0, 0));
          4, 5: pending_cmds.push_back(make_cmd(OP_CANCEL, 0, 4'($urandom_range(0, 15)),
                                       seq_ctr - $urandom_range(1, 12)));
          6, 7: pending_cmds.push_back(make_cmd(OP_ADVANCE, t, 0, 0));
          8: pending_cmds.push_back(make_cmd(OP_ADVANCE, {$urandom, $urandom}, 0, 0));
          default: pending_cmds.push_back(make_cmd(op_e'($urandom_range(0, 3)),
                     {$urandom, $urandom}, 4'($urandom_range(0, 15)), $urandom));
        endcase
      end
    end
    pending_cmds.push_back(make_cmd(OP_SCHEDULE, '1, 0, 0));
    pending_cmds.push_back(make_cmd(OP_ADVANCE, '1, 0, 0));
    pending_cmds.push_back(make_cmd(OP_ADVANCE, 64'd0, 0, 0));
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    drain_done = 1;
    repeat (100) @(posedge clk_i);

    $display("Covered %0d commands and %0d fired events, including a full table and stall.",
             cmds_sent, fired_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("event_timer_priority_queue verification clean");
    end else begin
      $display("event_timer_priority_queue verification failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/etpq_pkg.sv
hw/rtl/etpq_front.sv
hw/rtl/etpq_heap.sv
hw/rtl/event_timer_priority_queue.sv
sim/tb_event_timer_priority_queue.sv
